// ===== rtl/gdds_pkg.sv =====
// Package for the Gregorian date day stepper: widths, beat types, calendar helpers.
package gdds_pkg;

  // Working widths of the year and of the day count
  localparam int YEAR_BITS  = 16;
  localparam int COUNT_BITS = 16;

  // Year residue modulo 400 drives the leap rule
  localparam int R400_W = 9;
  localparam logic [R400_W-1:0] R400_LAST = 9'd399;
  localparam logic [R400_W-1:0] R400_C100 = 9'd100;
  localparam logic [R400_W-1:0] R400_C200 = 9'd200;
  localparam logic [R400_W-1:0] R400_C300 = 9'd300;

  // Order codes
  localparam logic [1:0] ORD_EARLIER = 2'd0;
  localparam logic [1:0] ORD_EQUAL   = 2'd1;
  localparam logic [1:0] ORD_LATER   = 2'd2;

  localparam logic [3:0] MON_JAN = 4'd1;
  localparam logic [3:0] MON_DEC = 4'd12;
  localparam logic [4:0] DAY_FIRST = 5'd1;
  localparam logic [4:0] DAY_LAST_DEC = 5'd31;

  localparam logic [4:0] PLAIN_LEN [12] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
                                            5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};
  localparam logic [4:0] LEAP_LEN  [12] = '{5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30,
                                            5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_CHECK,
    ST_STEP,
    ST_HOLD
  } st_t;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic [15:0] step_count;
    logic        step_down;
    logic [4:0]  other_day;
    logic [3:0]  other_month;
    logic [15:0] other_year;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [15:0] out_year;
    logic        date_valid;
    logic        range_error;
    logic [1:0]  order;
  } out_item_t;

  // Reduce a 16-bit port year to the working year width
  function automatic logic [YEAR_BITS-1:0] to_year(input logic [15:0] v);
    logic [YEAR_BITS+15:0] w;
    w = {{YEAR_BITS{1'b0}}, v};
    return w[YEAR_BITS-1:0];
  endfunction

  // Working year back to the 16-bit port
  function automatic logic [15:0] from_year(input logic [YEAR_BITS-1:0] v);
    logic [YEAR_BITS+15:0] w;
    w = {16'b0, v};
    return w[15:0];
  endfunction

  function automatic logic [COUNT_BITS-1:0] to_count(input logic [15:0] v);
    logic [COUNT_BITS+15:0] w;
    w = {{COUNT_BITS{1'b0}}, v};
    return w[COUNT_BITS-1:0];
  endfunction

  // Leap rule on the residue: divisible by 400, or by 4 and not by 100
  function automatic logic is_leap(input logic [R400_W-1:0] r);
    return (r == '0) ||
           ((r[1:0] == 2'b00) && (r != R400_C100) && (r != R400_C200) && (r != R400_C300));
  endfunction

  // Month length; months outside 1..12 read as 31 and are never stepped
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [3:0] idx;
    idx = m - 4'd1;
    if (m < MON_JAN || m > MON_DEC) return 5'd31;
    return leap ? LEAP_LEN[idx] : PLAIN_LEN[idx];
  endfunction

endpackage

// ===== rtl/gregorian_date_day_stepper.sv =====
// Gregorian date day stepper: validity check, date compare and month-wise stepping.
// Sequence: residue wait and validity check, then one step per month boundary crossed, one to finish
//   in the month and one to see the count run out, then the output register is loaded.
// Items: one at a time; a new item is taken only in idle, after the month-step loop has run and
//   the output register is loaded, which waits while out_valid is set and out_ready is held low.
// Reset: synchronous active-high rst returns the sequencer to idle and drops out_valid.
module gregorian_date_day_stepper
  import gdds_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int RW = COUNT_BITS + 6;

  st_t                   state, state_next;
  logic [4:0]            d, d_next;
  logic [3:0]            m, m_next;
  logic [YEAR_BITS-1:0]  y, y_next;
  logic [COUNT_BITS-1:0] rem, rem_next;
  logic                  down;
  logic [1:0]            ord;
  logic                  dvalid, dvalid_next;
  logic                  rerr, rerr_next;
  logic [R400_W-1:0]     r400, r400_next;
  logic                  out_valid_next;
  out_item_t             out_data_next;

  logic                  accept;
  logic                  mod_done;
  logic [R400_W-1:0]     mod_rem;
  logic [YEAR_BITS-1:0]  in_y, in_oy;
  logic [1:0]            in_ord;

  logic                  leap_cur, leap_prev;
  logic [R400_W-1:0]     r400_dec;
  logic [4:0]            mlen_cur, left;
  logic [3:0]            m_dec;
  logic [RW-1:0]         remw, leftw, dw;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  gdds_mod400 u_mod400 (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .value (in_y),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  // Compare on raw fields: year, then month, then day
  assign in_y  = to_year(in_data.year);
  assign in_oy = to_year(in_data.other_year);
  always_comb begin
    if (in_y != in_oy) begin
      in_ord = (in_y > in_oy) ? ORD_LATER : ORD_EARLIER;
    end else if (in_data.month != in_data.other_month) begin
      in_ord = (in_data.month > in_data.other_month) ? ORD_LATER : ORD_EARLIER;
    end else if (in_data.day != in_data.other_day) begin
      in_ord = (in_data.day > in_data.other_day) ? ORD_LATER : ORD_EARLIER;
    end else begin
      in_ord = ORD_EQUAL;
    end
  end

  // Calendar terms for the current and the preceding month
  assign leap_cur  = is_leap(r400);
  assign r400_dec  = (r400 == '0) ? R400_LAST : r400 - 1'b1;
  assign leap_prev = (m == MON_JAN) ? is_leap(r400_dec) : leap_cur;
  assign m_dec     = (m == MON_JAN) ? MON_DEC : m - 1'b1;
  assign mlen_cur  = month_len(m, leap_cur);
  assign left      = mlen_cur - d;
  assign remw      = {6'b0, rem};
  assign leftw     = {{(RW-5){1'b0}}, left};
  assign dw        = {{(RW-5){1'b0}}, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Working registers and output register
  always_ff @(posedge clk) begin
    if (accept) begin
      down <= in_data.step_down;
      ord  <= in_ord;
    end
    d        <= d_next;
    m        <= m_next;
    y        <= y_next;
    rem      <= rem_next;
    dvalid   <= dvalid_next;
    rerr     <= rerr_next;
    r400     <= r400_next;
    out_data <= out_data_next;
  end

  // Sequencer and the shared step unit
  always_comb begin
    state_next     = state;
    d_next         = d;
    m_next         = m;
    y_next         = y;
    rem_next       = rem;
    dvalid_next    = dvalid;
    rerr_next      = rerr;
    r400_next      = r400;
    out_valid_next = out_valid && !out_ready;
    out_data_next  = out_data;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          d_next     = in_data.day;
          m_next     = in_data.month;
          y_next     = in_y;
          rem_next   = to_count(in_data.step_count);
          rerr_next  = 1'b0;
          state_next = ST_MOD;
        end
      end

      ST_MOD: begin
        if (mod_done) begin
          r400_next  = mod_rem;
          state_next = ST_CHECK;
        end
      end

      ST_CHECK: begin
        dvalid_next = (m >= MON_JAN) && (m <= MON_DEC) && (d >= DAY_FIRST) &&
                      (d <= mlen_cur);
        state_next  = dvalid_next ? ST_STEP : ST_HOLD;
      end

      ST_STEP: begin
        if (rem == '0) begin
          state_next = ST_HOLD;
        end else if (!down) begin
          // Forward: finish inside this month or roll to the next
          if (remw <= leftw) begin
            d_next   = d + remw[4:0];
            rem_next = '0;
          end else begin
            rem_next = COUNT_BITS'(remw - leftw - 1'b1);
            d_next   = DAY_FIRST;
            if (m == MON_DEC) begin
              if (y == '1) begin
                d_next     = DAY_LAST_DEC;
                rerr_next  = 1'b1;
                state_next = ST_HOLD;
              end else begin
                y_next    = y + 1'b1;
                m_next    = MON_JAN;
                r400_next = (r400 == R400_LAST) ? '0 : r400 + 1'b1;
              end
            end else begin
              m_next = m + 1'b1;
            end
          end
        end else begin
          // Backward: finish inside this month or roll to the last day of the prior
          if (remw < dw) begin
            d_next   = d - remw[4:0];
            rem_next = '0;
          end else begin
            rem_next = COUNT_BITS'(remw - dw);
            if (m == MON_JAN && y == '0) begin
              d_next     = DAY_FIRST;
              rerr_next  = 1'b1;
              state_next = ST_HOLD;
            end else begin
              m_next = m_dec;
              d_next = month_len(m_dec, leap_prev);
              if (m == MON_JAN) begin
                y_next    = y - 1'b1;
                r400_next = r400_dec;
              end
            end
          end
        end
      end

      ST_HOLD: begin
        // Load the output register once the previous beat is gone
        if (!out_valid || out_ready) begin
          out_data_next.out_day     = d;
          out_data_next.out_month   = m;
          out_data_next.out_year    = from_year(y);
          out_data_next.date_valid  = dvalid;
          out_data_next.range_error = rerr;
          out_data_next.order       = ord;
          out_valid_next            = 1'b1;
          state_next                = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/gdds_mod400.sv =====
// Year residue modulo 400 by reciprocal multiplication; start loads operand and product, busy loads rem as done rises.
module gdds_mod400
  import gdds_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [YEAR_BITS-1:0] value,
  output logic                 done,
  output logic [R400_W-1:0]    rem
);

  // 400 = 16 * 25: the low four bits pass through, the upper bits are reduced mod 25
  localparam int XW = YEAR_BITS - 4;
  localparam int SH = YEAR_BITS + 1;
  localparam int KW = YEAR_BITS - 3;
  localparam int PW = XW + KW;
  localparam logic [KW-1:0] RECIP = KW'(((64'd1 << SH) + 64'd24) / 64'd25);

  logic          busy;
  logic [XW-1:0] x;
  logic [3:0]    lo;
  logic [PW-1:0] prod;
  logic [XW-1:0] q, q25, diff;

  // Quotient by 25 from the registered product, then the remainder
  assign q    = XW'(prod >> SH);
  assign q25  = (q << 4) + (q << 3) + q;
  assign diff = x - q25;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      done <= busy;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      x    <= value[YEAR_BITS-1:4];
      lo   <= value[3:0];
      prod <= PW'(value[YEAR_BITS-1:4]) * PW'(RECIP);
    end
    if (busy) begin
      rem <= {diff[4:0], lo};
    end
  end

endmodule
